### rtl/rtphd_pkg.sv
// ----------------------------------------------------------------------------
// rtphd_pkg: shared types and constants of the RTP H.264 depacketizer
// Header layout, FU-A codes, the Annex-B start code and the run descriptor
// that the parser hands to the output expander.
// ----------------------------------------------------------------------------
package rtphd_pkg;

  // RTP header and byte positions
  localparam logic [1:0] RTP_VERSION   = 2'd2;
  localparam logic [3:0] POS_FIRST     = 4'd0;
  localparam logic [3:0] POS_MARKER    = 4'd1;
  localparam logic [3:0] POS_SEQ_HI    = 4'd2;
  localparam logic [3:0] POS_SEQ_LO    = 4'd3;
  localparam logic [3:0] POS_TS_FIRST  = 4'd4;
  localparam logic [3:0] POS_TS_LAST   = 4'd7;
  localparam logic [3:0] HEADER_BYTES  = 4'd12;
  localparam logic [3:0] POS_FU_HEADER = 4'd13;
  localparam logic [3:0] POS_MAX       = 4'd14;

  // NAL unit codes
  localparam logic [4:0] FU_A_TYPE = 5'd28;
  localparam logic [1:0] NRI_MASK  = 2'h3;

  // Annex-B start code
  localparam logic [7:0] START_CODE [4] = '{8'h00, 8'h00, 8'h00, 8'h01};

  // Expander steps: 0..3 start code bytes, then payload byte, then frame end
  localparam logic [2:0] STEP_PREFIX = 3'd0;
  localparam logic [2:0] STEP_CODE_LAST = 3'd3;
  localparam logic [2:0] STEP_DATA   = 3'd4;
  localparam logic [2:0] STEP_END    = 3'd5;

  // Results caused by one input item
  typedef struct packed {
    logic        prefix;     // start code ahead of the data byte
    logic        data;       // one stream byte
    logic [7:0]  data_byte;
    logic        frame_end;  // frame end marker after the bytes
    logic [31:0] ts;
    logic        gap;
  } run_t;

endpackage

### rtl/rtphd_in_if.sv
// ----------------------------------------------------------------------------
// rtphd_in_if: datagram byte channel
// Valid/ready channel carrying one RTP datagram byte and its end flag.
// ----------------------------------------------------------------------------
interface rtphd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_packet;

  modport source (output valid, output in_byte, output end_of_packet, input ready);
  modport sink   (input valid, input in_byte, input end_of_packet, output ready);
endinterface

### rtl/rtphd_out_if.sv
// ----------------------------------------------------------------------------
// rtphd_out_if: Annex-B result channel
// Valid/ready channel carrying stream bytes and frame end markers.
// ----------------------------------------------------------------------------
interface rtphd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  out_byte;
  logic [31:0] frame_timestamp;
  logic        seq_gap;
  logic        last_of_run;

  modport source (output valid, output kind, output out_byte, output frame_timestamp,
                  output seq_gap, output last_of_run, input ready);
  modport sink   (input valid, input kind, input out_byte, input frame_timestamp,
                  input seq_gap, input last_of_run, output ready);
endinterface

### rtl/rtp_h264_depacketizer.sv
// Each accepted run is registered into the output slot, or the skid slot if busy.
// Throughput: one datagram byte per cycle while the skid slot is empty; each item
// holds the output slot until its 1, 2, 5 or 6 results (start code expansion) are out.
// A two-slot run buffer (skid slot plus output slot) sets the intake rate.
// Reset: synchronous active-low rst_n clears parser state and both slots;
// no clearing pass, the block accepts items as soon as reset is released.
// ----------------------------------------------------------------------------
// rtp_h264_depacketizer: RTP to Annex-B H.264 depacketizer
// Parses RTP datagrams byte by byte and emits an Annex-B stream with start
// codes, rebuilt FU-A NAL headers and frame end markers.
// ----------------------------------------------------------------------------
module rtp_h264_depacketizer (
  input  logic        clk,
  input  logic        rst_n,
  rtphd_in_if.sink    in_ch,
  rtphd_out_if.source out_ch
);

  logic            accept;
  logic            in_ready;
  logic            run_valid;
  rtphd_pkg::run_t run;

  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  // Header parse and run build
  rtphd_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_byte       (in_ch.in_byte),
    .end_of_packet (in_ch.end_of_packet),
    .run_valid     (run_valid),
    .run           (run)
  );

  // Run buffering and serialization
  rtphd_expander u_expander (
    .clk       (clk),
    .rst_n     (rst_n),
    .run_valid (run_valid),
    .run       (run),
    .in_ready  (in_ready),
    .out_ch    (out_ch)
  );

endmodule

### rtl/rtphd_parser.sv
// ----------------------------------------------------------------------------
// rtphd_parser: RTP header and FU-A parser
// Tracks the byte position in the datagram, captures header fields and
// builds the run of results that each accepted byte causes.
// ----------------------------------------------------------------------------
module rtphd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  input  logic              end_of_packet,
  output logic              run_valid,
  output rtphd_pkg::run_t   run
);

  logic [3:0]  pos_r,      pos_nxt;
  logic        dropped_r,  dropped_nxt;
  logic        marker_r,   marker_nxt;
  logic [15:0] prev_seq_r, prev_seq_nxt;
  logic [7:0]  seq_hi_r,   seq_hi_nxt;
  logic [31:0] ts_r,       ts_nxt;
  logic [7:0]  fu_ind_r,   fu_ind_nxt;
  logic        frag_r,     frag_nxt;
  logic        gap_r,      gap_nxt;

  logic        drop_now;
  logic        in_payload;
  logic        fe_marker;
  logic [15:0] seq_now;
  logic [7:0]  nal_hdr;
  rtphd_pkg::run_t run_c;

  assign drop_now   = (pos_r == rtphd_pkg::POS_FIRST) ?
                      (in_byte[7:6] != rtphd_pkg::RTP_VERSION) : dropped_r;
  assign in_payload = (pos_r >= rtphd_pkg::HEADER_BYTES);
  assign seq_now    = {seq_hi_r, in_byte};
  assign nal_hdr    = {1'b0, fu_ind_r[6:5] & rtphd_pkg::NRI_MASK, in_byte[4:0]};
  // FU end bit sets the marker on the FU header byte itself
  assign fe_marker  = marker_r | ((pos_r == rtphd_pkg::POS_FU_HEADER) && frag_r && in_byte[6]);

  // Run descriptor for this byte
  always_comb begin
    run_c           = '0;
    run_c.ts        = ts_r;
    run_c.gap       = gap_r;
    run_c.data_byte = in_byte;
    if (!drop_now && in_payload) begin
      if (pos_r == rtphd_pkg::HEADER_BYTES) begin
        if (in_byte[4:0] != rtphd_pkg::FU_A_TYPE) begin
          run_c.prefix = 1'b1;
          run_c.data   = 1'b1;
        end
      end else if (pos_r == rtphd_pkg::POS_FU_HEADER) begin
        if (frag_r) begin
          if (in_byte[7]) begin
            run_c.prefix    = 1'b1;
            run_c.data      = 1'b1;
            run_c.data_byte = nal_hdr;
          end
        end else begin
          run_c.data = 1'b1;
        end
      end else begin
        run_c.data = 1'b1;
      end
      run_c.frame_end = end_of_packet && fe_marker;
    end
  end

  assign run       = run_c;
  assign run_valid = accept && (run_c.prefix || run_c.data || run_c.frame_end);

  // Header state update
  always_comb begin
    pos_nxt      = pos_r;
    dropped_nxt  = dropped_r;
    marker_nxt   = marker_r;
    prev_seq_nxt = prev_seq_r;
    seq_hi_nxt   = seq_hi_r;
    ts_nxt       = ts_r;
    fu_ind_nxt   = fu_ind_r;
    frag_nxt     = frag_r;
    gap_nxt      = gap_r;
    if (accept) begin
      if (pos_r == rtphd_pkg::POS_FIRST) begin
        dropped_nxt = drop_now;
        marker_nxt  = 1'b0;
        frag_nxt    = 1'b0;
        gap_nxt     = 1'b0;
      end
      if (!drop_now) begin
        if (pos_r == rtphd_pkg::POS_MARKER) begin
          marker_nxt = in_byte[7];
        end else if (pos_r == rtphd_pkg::POS_SEQ_HI) begin
          seq_hi_nxt = in_byte;
        end else if (pos_r == rtphd_pkg::POS_SEQ_LO) begin
          gap_nxt      = ((prev_seq_r + 16'd1) != seq_now);
          prev_seq_nxt = seq_now;
        end else if (pos_r >= rtphd_pkg::POS_TS_FIRST && pos_r <= rtphd_pkg::POS_TS_LAST) begin
          ts_nxt = {ts_r[23:0], in_byte};
        end else if (pos_r == rtphd_pkg::HEADER_BYTES) begin
          frag_nxt = (in_byte[4:0] == rtphd_pkg::FU_A_TYPE);
          if (in_byte[4:0] == rtphd_pkg::FU_A_TYPE) begin
            fu_ind_nxt = in_byte;
          end
        end else if (pos_r == rtphd_pkg::POS_FU_HEADER) begin
          if (frag_r && in_byte[6]) begin
            marker_nxt = 1'b1;
          end
        end
      end
      // position saturates once past the FU header
      if (end_of_packet) begin
        pos_nxt     = rtphd_pkg::POS_FIRST;
        dropped_nxt = 1'b0;
        marker_nxt  = 1'b0;
        frag_nxt    = 1'b0;
      end else if (pos_r < rtphd_pkg::POS_MAX) begin
        pos_nxt = pos_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      dropped_r  <= 1'b0;
      marker_r   <= 1'b0;
      prev_seq_r <= '0;
      seq_hi_r   <= '0;
      ts_r       <= '0;
      fu_ind_r   <= '0;
      frag_r     <= 1'b0;
      gap_r      <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      dropped_r  <= dropped_nxt;
      marker_r   <= marker_nxt;
      prev_seq_r <= prev_seq_nxt;
      seq_hi_r   <= seq_hi_nxt;
      ts_r       <= ts_nxt;
      fu_ind_r   <= fu_ind_nxt;
      frag_r     <= frag_nxt;
      gap_r      <= gap_nxt;
    end
  end

endmodule

### rtl/rtphd_expander.sv
// ----------------------------------------------------------------------------
// rtphd_expander: result run expander
// Holds one run in a skid slot and one in the output slot, and walks the
// output slot through start code, stream byte and frame end, one per ready cycle.
// ----------------------------------------------------------------------------
module rtphd_expander (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              run_valid,
  input  rtphd_pkg::run_t   run,
  output logic              in_ready,
  rtphd_out_if.source       out_ch
);

  rtphd_pkg::run_t pend_r, pend_nxt;
  rtphd_pkg::run_t cur_r,  cur_nxt;
  logic            pend_valid_r, pend_valid_nxt;
  logic            cur_valid_r,  cur_valid_nxt;
  logic [2:0]      step_r, step_nxt;

  logic            last;
  logic            cur_free;
  logic            load_from_pend;
  logic            load_from_in;

  function automatic logic [2:0] first_step(input rtphd_pkg::run_t r);
    logic [2:0] s;
    if (r.prefix)    s = rtphd_pkg::STEP_PREFIX;
    else if (r.data) s = rtphd_pkg::STEP_DATA;
    else             s = rtphd_pkg::STEP_END;
    return s;
  endfunction

  assign last = (step_r == rtphd_pkg::STEP_END) ||
                ((step_r == rtphd_pkg::STEP_DATA) && !cur_r.frame_end);
  assign cur_free       = !cur_valid_r || (out_ch.ready && last);
  assign load_from_pend = pend_valid_r && cur_free;
  assign load_from_in   = run_valid && cur_free && !pend_valid_r;
  assign in_ready       = !pend_valid_r;

  // Slot control and step sequencing
  always_comb begin
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    cur_nxt        = cur_r;
    cur_valid_nxt  = cur_valid_r;
    step_nxt       = step_r;
    if (cur_free) begin
      cur_valid_nxt = pend_valid_r || load_from_in;
      if (load_from_pend) begin
        cur_nxt  = pend_r;
        step_nxt = first_step(pend_r);
      end else if (load_from_in) begin
        cur_nxt  = run;
        step_nxt = first_step(run);
      end
    end else if (out_ch.ready) begin
      if (step_r == rtphd_pkg::STEP_CODE_LAST) step_nxt = rtphd_pkg::STEP_DATA;
      else                                     step_nxt = step_r + 3'd1;
    end
    if (load_from_pend) begin
      pend_valid_nxt = 1'b0;
    end
    if (run_valid && !load_from_in) begin
      pend_nxt       = run;
      pend_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      cur_valid_r  <= 1'b0;
      step_r       <= rtphd_pkg::STEP_PREFIX;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      cur_valid_r  <= cur_valid_nxt;
      step_r       <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    cur_r  <= cur_nxt;
  end

  // Result fields for the current step
  always_comb begin
    out_ch.valid           = cur_valid_r;
    out_ch.kind            = (step_r == rtphd_pkg::STEP_END);
    out_ch.seq_gap         = cur_r.gap;
    out_ch.last_of_run     = last;
    out_ch.frame_timestamp = (step_r == rtphd_pkg::STEP_END) ? cur_r.ts : 32'd0;
    if (step_r < rtphd_pkg::STEP_DATA)       out_ch.out_byte = rtphd_pkg::START_CODE[step_r[1:0]];
    else if (step_r == rtphd_pkg::STEP_DATA) out_ch.out_byte = cur_r.data_byte;
    else                                     out_ch.out_byte = 8'd0;
  end

`ifndef ASSERT_OFF
  a_no_run_into_full_skid: assert property (@(posedge clk) disable iff (!rst_n)
    run_valid |-> !pend_valid_r)
    else $error("run arrived while skid slot full");
  a_skid_implies_cur: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> cur_valid_r)
    else $error("skid slot full with output slot empty");
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (step_r <= rtphd_pkg::STEP_END))
    else $error("expander step out of range");
  a_prefix_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_valid_r && (step_r < rtphd_pkg::STEP_DATA)) |-> (cur_r.prefix && cur_r.data))
    else $error("start code without stream byte");
  a_end_step_has_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_valid_r && (step_r == rtphd_pkg::STEP_END)) |-> cur_r.frame_end)
    else $error("frame end step without frame end");
`endif

endmodule
